>>> rtl/svbf_pkg.sv
`default_nettype none

package svbf_pkg;

	// Default sizes of the sample ring and the prefill phase.
	localparam int RING_DEPTH_DEF    = 32;
	localparam int PREFILL_COUNT_DEF = 10;

	// Field widths.
	localparam int READING_W = 15;
	localparam int VOLT_W    = 16;
	localparam int CAL_W     = 16;
	localparam int PREFILL_W = 4;

	// Four times the average reading.
	localparam int AVG4_W = READING_W + 2;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register indexes.
	localparam logic REG_CAL_DIVISOR = 1'b0;

	// Reset value of the calibration divisor.
	localparam logic [CAL_W-1:0] CAL_RESET = 16'd467;

endpackage

`default_nettype wire

>>> rtl/supply_voltage_boxcar_filter_top.sv
// Supply voltage boxcar filter.
// Input channel: in_valid / in_stall carry one item with adc_reading (15 bits)
// and take_sample. An item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall carry voltage_x10, one result per item,
// held in an output register so the next item can be taken while it waits.
// The calibration divisor is written through the APB port at address 0.
// The ring of recent readings lives in one synchronous memory. An item with
// take_sample reads the oldest entry, updates the running sum and writes the
// new reading back. The average comes from the sum by a reciprocal multiply,
// and a restoring divider then divides four times the average by the divisor,
// one quotient bit per cycle. An item passes through READ and UPD (only with
// take_sample), START, DIV2 and DONE, where the result moves to the output
// register once that is free; only then is the next item taken. The first
// PREFILL_COUNT items first sweep the whole ring in FILL, one entry per cycle.
// Reset restores the divisor to 467, clears the write slot and the sum and
// rearms the prefill phase; ring contents need no clearing, since the first
// item overwrites every entry. While the receiver stalls, the result stays in
// the output register; a following result waits in the block until it is free.
`default_nettype none

module supply_voltage_boxcar_filter_top #(
	parameter int RING_DEPTH    = svbf_pkg::RING_DEPTH_DEF,
	parameter int PREFILL_COUNT = svbf_pkg::PREFILL_COUNT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input channel.
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [svbf_pkg::READING_W-1:0]   adc_reading,
	input  wire logic                             take_sample,
	// Output channel.
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [svbf_pkg::VOLT_W-1:0]           voltage_x10,
	// Configuration port.
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [svbf_pkg::APB_AW-1:0]      paddr,
	input  wire logic [svbf_pkg::APB_DW-1:0]      pwdata,
	output logic [svbf_pkg::APB_DW-1:0]           prdata,
	output logic                                  pready
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int TW = svbf_pkg::READING_W + AW;
	localparam int QW = svbf_pkg::AVG4_W;
	localparam int DW = svbf_pkg::CAL_W;
	localparam int CW = $clog2((RING_DEPTH > QW) ? RING_DEPTH : QW);
	localparam int RW = svbf_pkg::READING_W;

	// Reciprocal of the ring depth, exact for every sum of TW bits.
	localparam int RS = TW + AW;
	localparam int MW = TW + 1;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << RS) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_UPD,
		ST_START,
		ST_DIV2,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [RW-1:0]                  reading_q;
	logic                           take_q;
	logic [AW-1:0]                  slot_q;
	logic [TW-1:0]                  total_q;
	logic [svbf_pkg::PREFILL_W-1:0] prefill_q;
	logic [CW-1:0]                  cnt_q;
	logic [QW-1:0]                  w_q;
	logic [DW-1:0]                  rem_q;
	logic [svbf_pkg::VOLT_W-1:0]    res_q;
	logic [svbf_pkg::VOLT_W-1:0]    out_q;
	logic                           out_valid_q;
	logic [DW-1:0]                  cal_q;

	logic [RW-1:0]                  ring_mem [RING_DEPTH];
	logic [RW-1:0]                  rd_s1;
	logic                           mem_we;
	logic [AW-1:0]                  mem_addr;

	logic                           in_acc;
	logic                           out_free;
	logic [DW-1:0]                  eff_div;
	logic [DW:0]                    rs;
	logic [DW:0]                    rs_sub;
	logic                           ge;
	logic [DW-1:0]                  rem_nx;
	logic [QW-1:0]                  w_nx;
	logic [TW+MW-1:0]               avg_prod;
	logic [QW-1:0]                  avg4;
	logic [QW-1:0]                  quo;
	logic [AW-1:0]                  slot_nx;

	// Handshake and port outputs.
	assign in_acc      = in_valid && !in_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign voltage_x10 = out_q;
	assign pready      = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= svbf_pkg::CAL_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == svbf_pkg::REG_CAL_DIVISOR) begin
			cal_q <= pwdata[DW-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == svbf_pkg::REG_CAL_DIVISOR) begin
			prdata = svbf_pkg::APB_DW'(cal_q);
		end else begin
			prdata = '0;
		end
	end

	// A divisor of zero acts as one.
	assign eff_div = (cal_q == '0) ? DW'(1) : cal_q;

	// Average of the ring by multiplying the sum with the reciprocal of the depth.
	assign avg_prod = total_q * RECIP;
	assign avg4     = {avg_prod[RS +: RW], 2'b00};

	// Divider step: four times the average divided by the divisor.
	assign rs     = {rem_q, w_q[QW-1]};
	assign rs_sub = rs - {1'b0, eff_div};
	assign ge     = (rs >= {1'b0, eff_div});
	assign rem_nx = ge ? rs_sub[DW-1:0] : rs[DW-1:0];
	assign w_nx   = {w_q[QW-2:0], ge};
	assign quo    = w_nx;

	assign slot_nx = (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + AW'(1);

	// Ring memory port: the sweep walks all entries, otherwise the write slot.
	assign mem_we   = (state_q == ST_FILL) || (state_q == ST_UPD);
	assign mem_addr = (state_q == ST_FILL) ? cnt_q[AW-1:0] : slot_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_addr] <= reading_q;
		end
		rd_s1 <= ring_mem[mem_addr];
	end

	// Sequencer, divider registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			reading_q   <= '0;
			take_q      <= 1'b0;
			slot_q      <= '0;
			total_q     <= '0;
			prefill_q   <= svbf_pkg::PREFILL_W'(PREFILL_COUNT);
			cnt_q       <= '0;
			w_q         <= '0;
			rem_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						reading_q <= adc_reading;
						take_q    <= take_sample;
						cnt_q     <= '0;
						if (prefill_q != '0) begin
							state_q <= ST_FILL;
						end else if (take_sample) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(RING_DEPTH - 1)) begin
						total_q   <= TW'(reading_q) * TW'(RING_DEPTH);
						prefill_q <= prefill_q - svbf_pkg::PREFILL_W'(1);
						state_q   <= take_q ? ST_READ : ST_START;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					total_q <= total_q - TW'(rd_s1) + TW'(reading_q);
					slot_q  <= slot_nx;
					state_q <= ST_START;
				end
				ST_START: begin
					w_q     <= avg4;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					w_q   <= w_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QW - 1)) begin
						res_q   <= quo[QW-1] ? '1 : quo[svbf_pkg::VOLT_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The partial remainder always stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV2) |-> (rem_q < eff_div))
		else $error("divider remainder not below divisor");

	// An item taken during prefill always starts a ring sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && prefill_q != '0) |=> (state_q == ST_FILL))
		else $error("prefill item did not sweep the ring");

	// The write slot never leaves the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= AW'(RING_DEPTH - 1))
		else $error("write slot beyond ring depth");

	// A new result never overwrites one the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=>
		(state_q == ST_DONE && $stable(out_q)))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
